### design/c3mf_pkg.sv
package c3mf_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 18;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_COUNT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_A     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_B     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_C     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_D     = 3'd6;

    // Register widths
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 16;
    localparam int FCOUNT_BITS = 3;
    localparam int KERNEL_BITS = 18;
    localparam int KERNELS     = 4;

    // Register reset values
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 16'd65535;
    localparam logic [FCOUNT_BITS-1:0] FCOUNT_RST = 3'd4;
    localparam logic [KERNEL_BITS-1:0] KERNEL_A_RST = 18'd1407;
    localparam logic [KERNEL_BITS-1:0] KERNEL_B_RST = 18'd29127;
    localparam logic [KERNEL_BITS-1:0] KERNEL_C_RST = 18'd259392;
    localparam logic [KERNEL_BITS-1:0] KERNEL_D_RST = 18'd216372;

    // Result field widths
    localparam int SUM_BITS  = 14;
    localparam int ROW_BITS  = 16;
    localparam int OCOL_BITS = 10;

    // 2-bit coefficient codes
    localparam logic [1:0] COEF_ZERO      = 2'b00;
    localparam logic [1:0] COEF_PLUS_ONE  = 2'b01;
    localparam logic [1:0] COEF_MINUS_TWO = 2'b10;
    localparam logic [1:0] COEF_MINUS_ONE = 2'b11;

endpackage

### design/c3mf_if.sv
interface c3mf_pix_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface c3mf_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [c3mf_pkg::SUM_BITS-1:0] sum_a;
    logic signed [c3mf_pkg::SUM_BITS-1:0] sum_b;
    logic signed [c3mf_pkg::SUM_BITS-1:0] sum_c;
    logic signed [c3mf_pkg::SUM_BITS-1:0] sum_d;
    logic [c3mf_pkg::ROW_BITS-1:0]        out_row;
    logic [c3mf_pkg::OCOL_BITS-1:0]       out_col;
    logic                                last_of_image;

    modport source (output valid, output sum_a, output sum_b, output sum_c, output sum_d,
                    output out_row, output out_col, output last_of_image, input ready);
    modport sink   (input valid, input sum_a, input sum_b, input sum_c, input sum_d,
                    input out_row, input out_col, input last_of_image, output ready);
endinterface

interface c3mf_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [c3mf_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [c3mf_pkg::CFG_DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/c3mf_line_store.sv
// Two stacked line stores in one memory: each entry holds {previous row, row before that}.
module c3mf_line_store #(
    parameter int DEPTH      = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int ADDR_BITS  = 10
) (
    input  logic                    clk,
    input  logic                    rd_en,
    input  logic [ADDR_BITS-1:0]    rd_addr,
    output logic [2*PIXEL_BITS-1:0] rd_data,
    input  logic                    wr_en,
    input  logic [ADDR_BITS-1:0]    wr_addr,
    input  logic [2*PIXEL_BITS-1:0] wr_data
);

    logic [2*PIXEL_BITS-1:0] mem [DEPTH];
    logic [2*PIXEL_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/c3mf_kernel.sv
// One 3x3 correlation: row partial sums registered, rows added on the way out.
module c3mf_kernel #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  load,
    input  logic                                  enable,
    input  logic [c3mf_pkg::KERNEL_BITS-1:0]      kernel,
    input  logic [PIXEL_BITS-1:0]                 window [3][3],
    output logic signed [c3mf_pkg::SUM_BITS-1:0]  sum
);

    localparam int PW = PIXEL_BITS + 2;
    localparam int RW = PIXEL_BITS + 4;
    localparam int TW = (PIXEL_BITS + 6 > c3mf_pkg::SUM_BITS) ? PIXEL_BITS + 6
                                                               : c3mf_pkg::SUM_BITS;

    logic signed [RW-1:0] row_next [3];
    logic signed [RW-1:0] row_reg  [3];
    logic                 en_reg;
    logic signed [TW-1:0] total;

    function automatic logic signed [PW-1:0] term(input logic [PIXEL_BITS-1:0] p,
                                                  input logic [1:0] code);
        logic signed [PW-1:0] ps;
        logic signed [PW-1:0] res;
        ps = $signed(PW'(p));
        case (code)
            c3mf_pkg::COEF_ZERO:      res = '0;
            c3mf_pkg::COEF_PLUS_ONE:  res = ps;
            c3mf_pkg::COEF_MINUS_TWO: res = -(ps <<< 1);
            c3mf_pkg::COEF_MINUS_ONE: res = -ps;
            default:                  res = '0;
        endcase
        return res;
    endfunction

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_next[r] = RW'(term(window[r][0], kernel[2*(r*3)     +: 2]))
                        + RW'(term(window[r][1], kernel[2*(r*3 + 1) +: 2]))
                        + RW'(term(window[r][2], kernel[2*(r*3 + 2) +: 2]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= row_next;
            en_reg  <= enable;
        end
    end

    assign total = TW'(row_reg[0]) + TW'(row_reg[1]) + TW'(row_reg[2]);
    assign sum   = en_reg ? total[c3mf_pkg::SUM_BITS-1:0] : '0;

endmodule

### design/conv3x3_multi_filter.sv
// 3x3 valid correlation over a raster pixel stream with four side-by-side kernels.
// Pixels enter on pix in raster order, one per clock while res keeps up, with no gaps needed; once
// a pixel completes a window (row >= 2, column >= 2) one result leaves on res
// carrying four 14-bit sums, the window's top-left row and column, and a mark on
// the last window of the image. Kernels at or beyond filter_count give zero.
// res.valid rises once the accepted pixel has passed stages A, B and C;
// throughput is one pixel per clock while res keeps up, set by the line
// store, which takes one read (at accept) and one write-back (when the pixel
// leaves the window stage) per cycle. The line store needs no clearing pass
// after reset: an entry is always written in a row before it is read for a
// window. Configuration registers (image_width, image_height, filter_count,
// kernel_a..kernel_d at indexes 0..6) must be written by the user through cfg
// while the block is idle; the block itself does not enforce it. cfg is always ready.
module conv3x3_multi_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    c3mf_cfg_if.sink          cfg,
    c3mf_pix_if.sink          pix,
    c3mf_res_if.source        res
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WCMP = (CW + 1 > c3mf_pkg::WIDTH_BITS) ? CW + 1 : c3mf_pkg::WIDTH_BITS;
    localparam int RB   = c3mf_pkg::ROW_BITS;
    localparam int KN   = c3mf_pkg::KERNELS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [c3mf_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [c3mf_pkg::HEIGHT_BITS-1:0] height_reg;
    logic [c3mf_pkg::FCOUNT_BITS-1:0] fcount_reg;
    logic [c3mf_pkg::KERNEL_BITS-1:0] kern_reg [KN];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= c3mf_pkg::WIDTH_RST;
            height_reg  <= c3mf_pkg::HEIGHT_RST;
            fcount_reg  <= c3mf_pkg::FCOUNT_RST;
            kern_reg[0] <= c3mf_pkg::KERNEL_A_RST;
            kern_reg[1] <= c3mf_pkg::KERNEL_B_RST;
            kern_reg[2] <= c3mf_pkg::KERNEL_C_RST;
            kern_reg[3] <= c3mf_pkg::KERNEL_D_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                c3mf_pkg::REG_IMAGE_WIDTH:  width_reg   <= cfg.data[c3mf_pkg::WIDTH_BITS-1:0];
                c3mf_pkg::REG_IMAGE_HEIGHT: height_reg  <= cfg.data[c3mf_pkg::HEIGHT_BITS-1:0];
                c3mf_pkg::REG_FILTER_COUNT: fcount_reg  <= cfg.data[c3mf_pkg::FCOUNT_BITS-1:0];
                c3mf_pkg::REG_KERNEL_A:     kern_reg[0] <= cfg.data;
                c3mf_pkg::REG_KERNEL_B:     kern_reg[1] <= cfg.data;
                c3mf_pkg::REG_KERNEL_C:     kern_reg[2] <= cfg.data;
                c3mf_pkg::REG_KERNEL_D:     kern_reg[3] <= cfg.data;
                default:                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effective image size: width clamped to [3, MAX_WIDTH], height to >= 3
    // ------------------------------------------------------------------
    logic [WCMP-1:0] width_ext;
    logic [WCMP-1:0] w_eff;
    logic [WCMP-1:0] w_last;
    logic [RB-1:0]   h_last;

    always_comb
    begin
        width_ext = WCMP'(width_reg);
        if (width_reg < c3mf_pkg::WIDTH_BITS'(3))
        begin
            w_eff = WCMP'(3);
        end
        else if (width_ext > WCMP'(MAX_WIDTH))
        begin
            w_eff = WCMP'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_ext;
        end
        w_last = w_eff - WCMP'(1);
        h_last = (height_reg < RB'(3)) ? RB'(2) : height_reg - RB'(1);
    end

    // ------------------------------------------------------------------
    // Raster position counters, advanced on every accepted item
    // ------------------------------------------------------------------
    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_next;
    logic [RB-1:0]   row_reg;
    logic [RB-1:0]   row_next;
    logic [CW-1:0]   c_eff;
    logic [WCMP-1:0] c_ext;
    logic            col_end;
    logic            emit;
    logic            last;
    logic            pix_acc;

    always_comb
    begin
        c_eff   = (WCMP'(col_reg) >= WCMP'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) : col_reg;
        c_ext   = WCMP'(c_eff);
        col_end = (c_ext >= w_last);
        emit    = (row_reg >= RB'(2)) && (c_eff >= CW'(2));
        last    = (row_reg == h_last) && (c_ext == w_last);
        if (col_end)
        begin
            col_next = '0;
            row_next = (row_reg >= h_last) ? '0 : row_reg + RB'(1);
        end
        else
        begin
            col_next = c_eff + CW'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    //   A: line store read in flight, window assembled, row sums formed
    //   B: row sums held, rows added
    //   C: result register on res
    // Items that complete no window still pass A to update the line store
    // and window, then drop at B.
    // ------------------------------------------------------------------
    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic c_valid_reg, c_valid_next;
    logic b_emit_reg;
    logic adv_a;
    logic adv_b;
    logic res_acc;

    assign res_acc   = c_valid_reg && res.ready;
    assign adv_b     = b_valid_reg && (!b_emit_reg || !c_valid_reg || res.ready);
    assign adv_a     = a_valid_reg && (!b_valid_reg || adv_b);
    assign pix.ready = !a_valid_reg || adv_a;
    assign pix_acc   = pix.valid && pix.ready;

    always_comb
    begin
        a_valid_next = pix_acc ? 1'b1 : (adv_a ? 1'b0 : a_valid_reg);
        b_valid_next = adv_a ? 1'b1 : (adv_b ? 1'b0 : b_valid_reg);
        if (adv_b && b_emit_reg)
        begin
            c_valid_next = 1'b1;
        end
        else if (res_acc)
        begin
            c_valid_next = 1'b0;
        end
        else
        begin
            c_valid_next = c_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A payload
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] a_pix_reg;
    logic [CW-1:0]         a_col_reg;
    logic [CW-1:0]         a_ocol_reg;
    logic [RB-1:0]         a_orow_reg;
    logic                  a_emit_reg;
    logic                  a_last_reg;

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            a_pix_reg  <= pix.pixel;
            a_col_reg  <= c_eff;
            a_ocol_reg <= c_eff - CW'(2);
            a_orow_reg <= row_reg - RB'(2);
            a_emit_reg <= emit;
            a_last_reg <= last;
        end
    end

    // ------------------------------------------------------------------
    // Line store: read column at accept, write back {pixel, prev} when A leaves
    // ------------------------------------------------------------------
    logic [2*PIXEL_BITS-1:0] line_rd;
    logic [PIXEL_BITS-1:0]   prev;
    logic [PIXEL_BITS-1:0]   prev2;

    c3mf_line_store #(
        .DEPTH      (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .ADDR_BITS  (CW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (pix_acc),
        .rd_addr (c_eff),
        .rd_data (line_rd),
        .wr_en   (adv_a),
        .wr_addr (a_col_reg),
        .wr_data ({a_pix_reg, prev})
    );

    assign prev  = line_rd[2*PIXEL_BITS-1:PIXEL_BITS];
    assign prev2 = line_rd[PIXEL_BITS-1:0];

    // ------------------------------------------------------------------
    // Window: two stored columns plus the new column (line stores and pixel)
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] wcol_reg [3][2];
    logic [PIXEL_BITS-1:0] window   [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            window[r][0] = wcol_reg[r][0];
            window[r][1] = wcol_reg[r][1];
        end
        window[0][2] = prev2;
        window[1][2] = prev;
        window[2][2] = a_pix_reg;
    end

    // shift the window left by one column as each item leaves A
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                wcol_reg[r][0] <= '0;
                wcol_reg[r][1] <= '0;
            end
        end
        else if (adv_a)
        begin
            for (int r = 0; r < 3; r++)
            begin
                wcol_reg[r][0] <= wcol_reg[r][1];
                wcol_reg[r][1] <= window[r][2];
            end
        end
    end

    // ------------------------------------------------------------------
    // Kernels: row sums registered into B, rows added between B and C
    // ------------------------------------------------------------------
    logic signed [c3mf_pkg::SUM_BITS-1:0] ksum [KN];

    for (genvar k = 0; k < KN; k++)
    begin : g_kernel
        c3mf_kernel #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_kernel (
            .clk    (clk),
            .load   (adv_a),
            .enable (fcount_reg > c3mf_pkg::FCOUNT_BITS'(k)),
            .kernel (kern_reg[k]),
            .window (window),
            .sum    (ksum[k])
        );
    end

    // ------------------------------------------------------------------
    // Stage B payload
    // ------------------------------------------------------------------
    logic [CW-1:0] b_ocol_reg;
    logic [RB-1:0] b_orow_reg;
    logic          b_last_reg;

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            b_emit_reg <= a_emit_reg;
            b_ocol_reg <= a_ocol_reg;
            b_orow_reg <= a_orow_reg;
            b_last_reg <= a_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: result register
    // ------------------------------------------------------------------
    logic signed [c3mf_pkg::SUM_BITS-1:0] c_sum_reg [KN];
    logic [RB-1:0]                        c_row_reg;
    logic [c3mf_pkg::OCOL_BITS-1:0]       c_col_reg;
    logic                                 c_last_reg;
    logic [CW+c3mf_pkg::OCOL_BITS-1:0]    ocol_wide;

    assign ocol_wide = (CW + c3mf_pkg::OCOL_BITS)'(b_ocol_reg);

    always_ff @(posedge clk)
    begin
        if (adv_b && b_emit_reg)
        begin
            c_sum_reg  <= ksum;
            c_row_reg  <= b_orow_reg;
            c_col_reg  <= ocol_wide[c3mf_pkg::OCOL_BITS-1:0];
            c_last_reg <= b_last_reg;
        end
    end

    assign res.valid         = c_valid_reg;
    assign res.sum_a         = c_sum_reg[0];
    assign res.sum_b         = c_sum_reg[1];
    assign res.sum_c         = c_sum_reg[2];
    assign res.sum_d         = c_sum_reg[3];
    assign res.out_row       = c_row_reg;
    assign res.out_col       = c_col_reg;
    assign res.last_of_image = c_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // hold line store read data while stage A stalls
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !adv_a) |=> (line_rd === $past(line_rd)))
        else $error("line store read data changed under a stalled item");

    // write-back and new read never hit the same column in one cycle
    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (adv_a && pix_acc) |-> (a_col_reg != c_eff))
        else $error("line store read and write collide on one column");

    // a result appears only from an item that completes a window
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(c_valid_reg) |-> $past(b_valid_reg && b_emit_reg))
        else $error("result raised without a window-completing item");

    // stage A never stalls while stage B is empty
    a_a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_valid_reg) |-> adv_a)
        else $error("stage A stalled with stage B empty");

endmodule
